@@ rtl/dcrs_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dcrs_pkg
// Types, step codes and the microprogram of the divisor count range sum block.
// ---------------------------------------------------------------------------
package dcrs_pkg;

  localparam int OPERAND_WIDTH = 32;
  localparam int TOTAL_WIDTH   = 37;
  localparam int STEP_WIDTH    = 4;
  localparam int PHASE_WIDTH   = 2;

  // pass phase codes
  localparam logic [PHASE_WIDTH-1:0] PHASE_IDLE  = 2'd0;
  localparam logic [PHASE_WIDTH-1:0] PHASE_LOWER = 2'd1;
  localparam logic [PHASE_WIDTH-1:0] PHASE_UPPER = 2'd2;

  // step addresses of the microprogram
  localparam logic [STEP_WIDTH-1:0] STEP_IDLE      = 4'd0;
  localparam logic [STEP_WIDTH-1:0] STEP_CHECK     = 4'd1;
  localparam logic [STEP_WIDTH-1:0] STEP_ZERO_TEST = 4'd2;
  localparam logic [STEP_WIDTH-1:0] STEP_DIV_LEFT  = 4'd3;
  localparam logic [STEP_WIDTH-1:0] STEP_WAIT_Q    = 4'd4;
  localparam logic [STEP_WIDTH-1:0] STEP_DIV_Q     = 4'd5;
  localparam logic [STEP_WIDTH-1:0] STEP_WAIT_R    = 4'd6;
  localparam logic [STEP_WIDTH-1:0] STEP_MUL       = 4'd7;
  localparam logic [STEP_WIDTH-1:0] STEP_ACC       = 4'd8;
  localparam logic [STEP_WIDTH-1:0] STEP_LOOP      = 4'd9;
  localparam logic [STEP_WIDTH-1:0] STEP_PASS_END  = 4'd10;
  localparam logic [STEP_WIDTH-1:0] STEP_FINISH    = 4'd11;
  localparam logic [STEP_WIDTH-1:0] STEP_ERROR     = 4'd12;

  typedef struct packed {
    logic [OPERAND_WIDTH-1:0] range_low;
    logic [OPERAND_WIDTH-1:0] range_high;
  } in_item_t;

  typedef struct packed {
    logic [TOTAL_WIDTH-1:0] divisor_total;
    logic                   range_error;
  } out_item_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD_IN,
    OP_INIT_LOWER,
    OP_DIV_LEFT,
    OP_LOAD_Q,
    OP_DIV_Q,
    OP_LOAD_R,
    OP_MUL,
    OP_ACC,
    OP_PASS_END,
    OP_WRITE_OUT,
    OP_WRITE_ERR
  } op_e;

  // sequencing kinds
  typedef enum logic [1:0] {
    BR_NEXT,
    BR_JUMP,
    BR_IF,
    BR_WAIT
  } br_e;

  // branch conditions
  typedef enum logic [2:0] {
    C_NONE,
    C_IN_VALID,
    C_ERR,
    C_XZERO,
    C_DIV_DONE,
    C_RIGHT_END,
    C_LOWER,
    C_OUT_FREE
  } cond_e;

  typedef struct packed {
    op_e                   op;
    br_e                   br;
    cond_e                 cond;
    logic [STEP_WIDTH-1:0] target;
  } uword_t;

  // status flags from the datapath to the sequencer
  typedef struct packed {
    logic in_valid;
    logic err;
    logic x_zero;
    logic div_done;
    logic right_end;
    logic lower;
    logic out_free;
  } status_t;

  // control from the sequencer to the datapath
  typedef struct packed {
    op_e  op;
    logic fire;
    logic idle;
  } ctrl_t;

  // microprogram rom
  function automatic uword_t ucode_rom(input logic [STEP_WIDTH-1:0] step);
    uword_t w;
    w = '{op: OP_NOP, br: BR_JUMP, cond: C_NONE, target: STEP_IDLE};
    case (step)
      STEP_IDLE:      w = '{OP_LOAD_IN,    BR_WAIT, C_IN_VALID,  STEP_CHECK};
      STEP_CHECK:     w = '{OP_INIT_LOWER, BR_IF,   C_ERR,       STEP_ERROR};
      STEP_ZERO_TEST: w = '{OP_NOP,        BR_IF,   C_XZERO,     STEP_PASS_END};
      STEP_DIV_LEFT:  w = '{OP_DIV_LEFT,   BR_NEXT, C_NONE,      STEP_IDLE};
      STEP_WAIT_Q:    w = '{OP_LOAD_Q,     BR_WAIT, C_DIV_DONE,  STEP_DIV_Q};
      STEP_DIV_Q:     w = '{OP_DIV_Q,      BR_NEXT, C_NONE,      STEP_IDLE};
      STEP_WAIT_R:    w = '{OP_LOAD_R,     BR_WAIT, C_DIV_DONE,  STEP_MUL};
      STEP_MUL:       w = '{OP_MUL,        BR_NEXT, C_NONE,      STEP_IDLE};
      STEP_ACC:       w = '{OP_ACC,        BR_IF,   C_RIGHT_END, STEP_PASS_END};
      STEP_LOOP:      w = '{OP_NOP,        BR_JUMP, C_NONE,      STEP_DIV_LEFT};
      STEP_PASS_END:  w = '{OP_PASS_END,   BR_IF,   C_LOWER,     STEP_ZERO_TEST};
      STEP_FINISH:    w = '{OP_WRITE_OUT,  BR_WAIT, C_OUT_FREE,  STEP_IDLE};
      STEP_ERROR:     w = '{OP_WRITE_ERR,  BR_WAIT, C_OUT_FREE,  STEP_IDLE};
      default:        w = '{OP_NOP,        BR_JUMP, C_NONE,      STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

@@ rtl/divisor_count_range_sum.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// divisor_count_range_sum
// Total divisor count of a..b as D(b) - D(a-1), with D(x) formed by walking
// blocks of equal quotient under control of a microcoded sequencer.
// ---------------------------------------------------------------------------
// steps: two divider waits and five control steps per quotient block (the
//   last block of a pass skips the loop step) over both prefix passes; an
//   error item skips both passes
// throughput: one item at a time, set by the shared bit-serial divider;
//   the next item is taken while a finished result waits in the output register
// reset: asynchronous, active low; sequencer idle, divider stopped, no result
// ---------------------------------------------------------------------------
module divisor_count_range_sum (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dcrs_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dcrs_pkg::out_item_t out_item_o
);
  import dcrs_pkg::*;

  // datapath registers
  logic [OPERAND_WIDTH-1:0] a_q, a_d;
  logic [OPERAND_WIDTH-1:0] b_q, b_d;
  logic [OPERAND_WIDTH-1:0] bound_q, bound_d;
  logic [OPERAND_WIDTH-1:0] left_q, left_d;
  logic [OPERAND_WIDTH-1:0] quot_q, quot_d;
  logic [OPERAND_WIDTH-1:0] right_q, right_d;
  logic [TOTAL_WIDTH-1:0]   prod_q, prod_d;
  logic [TOTAL_WIDTH-1:0]   acc_q, acc_d;
  logic [TOTAL_WIDTH-1:0]   lower_q, lower_d;
  logic [PHASE_WIDTH-1:0]   phase_q, phase_d;
  out_item_t                out_q, out_d;
  logic                     out_valid_q, out_valid_d;

  status_t                  status;
  ctrl_t                    ctrl;
  logic                     div_start;
  logic                     div_done;
  logic [OPERAND_WIDTH-1:0] div_divisor;
  logic [OPERAND_WIDTH-1:0] div_quotient;
  logic [OPERAND_WIDTH-1:0] block_len;
  logic [2*OPERAND_WIDTH-1:0] full_prod;
  logic                     out_free;

  dcrs_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  // shared divider, divisor is the block start or the quotient
  assign div_start   = ctrl.fire && ((ctrl.op == OP_DIV_LEFT) || (ctrl.op == OP_DIV_Q));
  assign div_divisor = (ctrl.op == OP_DIV_Q) ? quot_q : left_q;

  dcrs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (bound_q),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  // status back to the sequencer
  assign out_free         = !out_valid_q || !out_stall_i;
  assign status.in_valid  = in_valid_i;
  assign status.err       = (a_q == '0) || (a_q > b_q);
  assign status.x_zero    = (bound_q == '0);
  assign status.div_done  = div_done;
  assign status.right_end = (right_q >= bound_q);
  assign status.lower     = (phase_q == PHASE_LOWER);
  assign status.out_free  = out_free;

  // block length times quotient
  assign block_len = right_q - left_q + 1'b1;
  assign full_prod = quot_q * block_len;

  // datapath operations
  always_comb begin
    a_d       = a_q;
    b_d       = b_q;
    bound_d   = bound_q;
    left_d    = left_q;
    quot_d    = quot_q;
    right_d   = right_q;
    prod_d    = prod_q;
    acc_d     = acc_q;
    lower_d   = lower_q;
    phase_d   = phase_q;
    out_d     = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (ctrl.fire) begin
      case (ctrl.op)
        OP_NOP: begin
        end
        OP_LOAD_IN: begin
          a_d = in_item_i.range_low;
          b_d = in_item_i.range_high;
        end
        OP_INIT_LOWER: begin
          bound_d = a_q - 1'b1;
          acc_d   = '0;
          left_d  = OPERAND_WIDTH'(1);
          phase_d = PHASE_LOWER;
        end
        OP_DIV_LEFT: begin
        end
        OP_LOAD_Q: begin
          quot_d = div_quotient;
        end
        OP_DIV_Q: begin
        end
        OP_LOAD_R: begin
          right_d = div_quotient;
        end
        OP_MUL: begin
          prod_d = full_prod[TOTAL_WIDTH-1:0];
        end
        OP_ACC: begin
          acc_d  = acc_q + prod_q;
          left_d = right_q + 1'b1;
        end
        OP_PASS_END: begin
          if (phase_q == PHASE_LOWER) begin
            lower_d = acc_q;
            bound_d = b_q;
            acc_d   = '0;
            left_d  = OPERAND_WIDTH'(1);
            phase_d = PHASE_UPPER;
          end
        end
        OP_WRITE_OUT: begin
          out_d.divisor_total = acc_q - lower_q;
          out_d.range_error   = 1'b0;
          out_valid_d         = 1'b1;
          phase_d             = PHASE_IDLE;
        end
        OP_WRITE_ERR: begin
          out_d.divisor_total = '0;
          out_d.range_error   = 1'b1;
          out_valid_d         = 1'b1;
          phase_d             = PHASE_IDLE;
        end
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PHASE_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    b_q     <= b_d;
    bound_q <= bound_d;
    left_q  <= left_d;
    quot_q  <= quot_d;
    right_q <= right_d;
    prod_q  <= prod_d;
    acc_q   <= acc_d;
    lower_q <= lower_d;
    out_q   <= out_d;
  end

  assign in_stall_o  = !ctrl.idle;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

@@ rtl/dcrs_div.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dcrs_div
// Radix-2 restoring divider, one quotient bit per cycle, quotient only.
// ---------------------------------------------------------------------------
module dcrs_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [dcrs_pkg::OPERAND_WIDTH-1:0] dividend_i,
  input  logic [dcrs_pkg::OPERAND_WIDTH-1:0] divisor_i,
  output logic                              done_o,
  output logic [dcrs_pkg::OPERAND_WIDTH-1:0] quotient_o
);
  import dcrs_pkg::*;

  localparam int CNT_WIDTH = $clog2(OPERAND_WIDTH + 1);

  logic [OPERAND_WIDTH-1:0] rem_q, rem_d;
  logic [OPERAND_WIDTH-1:0] quo_q, quo_d;
  logic [OPERAND_WIDTH-1:0] dsr_q, dsr_d;
  logic [CNT_WIDTH-1:0]     cnt_q, cnt_d;
  logic                     done_q, done_d;
  logic [OPERAND_WIDTH:0]   shifted;
  logic [OPERAND_WIDTH:0]   trial;

  // one trial subtraction per cycle
  assign shifted = {rem_q, quo_q[OPERAND_WIDTH-1]};
  assign trial   = shifted - {1'b0, dsr_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      dsr_d = divisor_i;
      cnt_d = CNT_WIDTH'(OPERAND_WIDTH);
    end else if (cnt_q != '0) begin
      if (!trial[OPERAND_WIDTH]) begin
        rem_d = trial[OPERAND_WIDTH-1:0];
        quo_d = {quo_q[OPERAND_WIDTH-2:0], 1'b1};
      end else begin
        rem_d = shifted[OPERAND_WIDTH-1:0];
        quo_d = {quo_q[OPERAND_WIDTH-2:0], 1'b0};
      end
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_WIDTH'(1));
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // operand registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ rtl/dcrs_seq.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dcrs_seq
// Step counter and microprogram rom with conditional jumps and wait steps.
// ---------------------------------------------------------------------------
module dcrs_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dcrs_pkg::status_t status_i,
  output dcrs_pkg::ctrl_t   ctrl_o
);
  import dcrs_pkg::*;

  logic [STEP_WIDTH-1:0] step_q, step_d;
  uword_t                uw;
  logic                  cond_true;

  assign uw = ucode_rom(step_q);

  // condition select
  always_comb begin
    case (uw.cond)
      C_NONE:      cond_true = 1'b0;
      C_IN_VALID:  cond_true = status_i.in_valid;
      C_ERR:       cond_true = status_i.err;
      C_XZERO:     cond_true = status_i.x_zero;
      C_DIV_DONE:  cond_true = status_i.div_done;
      C_RIGHT_END: cond_true = status_i.right_end;
      C_LOWER:     cond_true = status_i.lower;
      C_OUT_FREE:  cond_true = status_i.out_free;
      default:     cond_true = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    case (uw.br)
      BR_NEXT: step_d = step_q + 1'b1;
      BR_JUMP: step_d = uw.target;
      BR_IF:   step_d = cond_true ? uw.target : step_q + 1'b1;
      BR_WAIT: step_d = cond_true ? uw.target : step_q;
      default: step_d = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  // a wait step performs its operation only on the cycle it leaves
  assign ctrl_o.op   = uw.op;
  assign ctrl_o.fire = (uw.br != BR_WAIT) || cond_true;
  assign ctrl_o.idle = (step_q == STEP_IDLE);

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Checks divisor_count_range_sum against its own prediction of the divisor
// count total D(b) - D(a-1). Range errors, small and wide ranges, a long
// output hold-off and random items under several idle and stall mixes are
// sent, and every result is compared field by field in arrival order.
// ---------------------------------------------------------------------------
module testbench;

  import dcrs_pkg::*;

  localparam int CLK_PERIOD  = 20;
  localparam int RESET_TICKS = 9;
  localparam int HOLD_CYCLES = 4000;
  localparam int DRAIN_TICKS = 200;

  logic      clk_i = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  in_item_t  in_item = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_item;

  // random idle and stall rates, in percent
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  // long output hold-off
  logic hold_request = 1'b0;
  int   hold_left = 0;

  out_item_t expected_totals[$];
  out_item_t wanted;
  int        fail_count = 0;

  divisor_count_range_sum uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  // clock
  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // D(x): sum of floor(x/k) for k = 1..x, walked by equal-quotient blocks
  function automatic longint unsigned divisor_prefix(longint unsigned x);
    longint unsigned left;
    longint unsigned quot;
    longint unsigned right;
    longint unsigned acc;
    acc = 0;
    left = 1;
    while (left <= x) begin
      quot = x / left;
      right = x / quot;
      acc += quot * (right - left + 1);
      left = right + 1;
    end
    return acc;
  endfunction

  // expected result of one range item
  function automatic out_item_t predict_total(in_item_t item);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned total;
    out_item_t res;
    lo = item.range_low;
    hi = item.range_high;
    if (lo == 0 || lo > hi) begin
      res.divisor_total = '0;
      res.range_error = 1'b1;
    end else begin
      total = divisor_prefix(hi) - divisor_prefix(lo - 1);
      res.divisor_total = total[TOTAL_WIDTH-1:0];
      res.range_error = 1'b0;
    end
    return res;
  endfunction

  // receiver stall, with the long hold-off counted here
  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
    if (hold_request || hold_left > 1) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    if (out_valid && !out_stall) begin
      if (expected_totals.size() == 0) begin
        $error("unexpected result: divisor_total %0d range_error %0d",
               out_item.divisor_total, out_item.range_error);
        fail_count++;
      end else begin
        wanted = expected_totals.pop_front();
        if (out_item.divisor_total !== wanted.divisor_total) begin
          $error("divisor_total: expected %0d, actual %0d",
                 wanted.divisor_total, out_item.divisor_total);
          fail_count++;
        end
        if (out_item.range_error !== wanted.range_error) begin
          $error("range_error: expected %0d, actual %0d",
                 wanted.range_error, out_item.range_error);
          fail_count++;
        end
      end
    end
  end

  // offer one item, with random sender idling, until it is accepted
  task automatic send_range(input logic [OPERAND_WIDTH-1:0] lo,
                            input logic [OPERAND_WIDTH-1:0] hi);
    in_item_t item;
    item.range_low = lo;
    item.range_high = hi;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item <= item;
    do @(posedge clk_i); while (in_stall);
    expected_totals.insert(expected_totals.size(), predict_total(item));
  endtask

  task automatic apply_reset();
    rst_n <= 1'b0;
    repeat (RESET_TICKS) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
  endtask

  // zero low bound and reversed ranges, with extreme operands
  task automatic test_range_errors();
    send_range(32'd0, 32'd0);
    send_range(32'd0, 32'hFFFF_FFFF);
    send_range(32'hFFFF_FFFF, 32'd0);
    send_range(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_range(32'd2, 32'd1);
    send_range(32'h8000_0000, 32'h7FFF_FFFF);
    send_range(32'hAAAA_AAAA, 32'h5555_5555);
    send_range(32'd0, 32'h5555_5555);
  endtask

  // single points, ranges starting at one and short ranges
  task automatic test_small_ranges();
    send_range(32'd1, 32'd1);
    send_range(32'd1, 32'd2);
    send_range(32'd2, 32'd2);
    send_range(32'd1, 32'd12);
    send_range(32'd7, 32'd7);
    send_range(32'd16, 32'd16);
    send_range(32'd1, 32'd100);
    send_range(32'd50, 32'd60);
  endtask

  // two ranges with many quotient blocks
  task automatic test_wide_ranges();
    send_range(32'd1, 32'd200000);
    send_range(32'd100000, 32'd150000);
  endtask

  // hold the output for a long stretch while items keep coming
  task automatic test_backpressure();
    in_valid <= 1'b0;
    // let earlier items drain so the hold-off meets an empty block
    while (expected_totals.size() != 0) @(posedge clk_i);
    hold_request <= 1'b1;
    @(posedge clk_i);
    hold_request <= 1'b0;
    repeat (6) send_range($urandom_range(20, 1), $urandom_range(40, 20));
  endtask

  // random mix: mostly valid small ranges, some errors with full-width operands
  task automatic test_random_items(input int idle_pct, input int stall_pct,
                                   input int count);
    logic [OPERAND_WIDTH-1:0] lo;
    logic [OPERAND_WIDTH-1:0] hi;
    logic [OPERAND_WIDTH-1:0] swap;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (count) begin
      if ($urandom_range(9) < 3) begin
        lo = $urandom();
        hi = $urandom();
        if ($urandom_range(3) == 0 || lo == hi) begin
          lo = '0;
        end else if (lo < hi) begin
          swap = lo;
          lo = hi;
          hi = swap;
        end
      end else begin
        if ($urandom_range(19) == 0) begin
          hi = $urandom_range(5000, 1);
        end else begin
          hi = $urandom_range(400, 1);
        end
        lo = $urandom_range(hi, 1);
      end
      send_range(lo, hi);
    end
  endtask

  // test sequence
  initial begin
    apply_reset();
    test_range_errors();
    test_small_ranges();
    test_wide_ranges();
    test_backpressure();
    test_random_items(0, 0, 25);
    test_random_items(85, 0, 25);
    test_random_items(0, 85, 25);
    test_random_items(9, 9, 25);
    in_valid <= 1'b0;
    while (expected_totals.size() != 0) @(posedge clk_i);
    repeat (DRAIN_TICKS) @(posedge clk_i);
    if (expected_totals.size() != 0) begin
      $error("results missing: %0d", expected_totals.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #200000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ divisor_count_range_sum.f @@
rtl/dcrs_pkg.sv
rtl/dcrs_div.sv
rtl/dcrs_seq.sv
rtl/divisor_count_range_sum.sv
tb/sv/testbench.sv
